// ===== rtl/mts_pkg.sv =====
// mts_pkg: shared types and codes of the memory test sequencer
// used by mts_step, memory_test_sequencer and mts_checker; no dependencies

package mts_pkg;

    localparam int OFF_W  = 17;
    localparam int FAIL_W = 32;
    localparam int CFG_W  = 17;

    // phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_DB_WR   = 4'd1;
    localparam logic [3:0] PH_DB_RD   = 4'd2;
    localparam logic [3:0] PH_AB_FILL = 4'd3;
    localparam logic [3:0] PH_AB_HIB  = 4'd4;
    localparam logic [3:0] PH_AB_HIR  = 4'd5;
    localparam logic [3:0] PH_AB_HIE  = 4'd6;
    localparam logic [3:0] PH_AB_LOP  = 4'd7;
    localparam logic [3:0] PH_AB_LO0  = 4'd8;
    localparam logic [3:0] PH_AB_LOR  = 4'd9;
    localparam logic [3:0] PH_AB_LOE  = 4'd10;
    localparam logic [3:0] PH_DV_FILL = 4'd11;
    localparam logic [3:0] PH_DV_C1R  = 4'd12;
    localparam logic [3:0] PH_DV_C1W  = 4'd13;
    localparam logic [3:0] PH_DV_C2R  = 4'd14;

    // test status
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PASS = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // test select
    localparam logic [1:0] TS_DATA_BUS = 2'd0;
    localparam logic [1:0] TS_ADDR_BUS = 2'd1;
    localparam logic [1:0] TS_DEVICE   = 2'd2;
    localparam logic [1:0] TS_NONE     = 2'd3;

    // register indexes
    localparam logic [1:0] REG_TEST_SELECT = 2'd0;
    localparam logic [1:0] REG_BASE_ADDR   = 2'd1;
    localparam logic [1:0] REG_WORD_COUNT  = 2'd2;

    localparam logic [OFF_W-1:0] WORD_COUNT_RST = 17'h10000;

    typedef struct packed {
        logic [3:0]        phase;
        logic [OFF_W-1:0]  scan;
        logic [OFF_W-1:0]  probe;
        logic              pending;
        logic [1:0]        status;
        logic [FAIL_W-1:0] fail;
    } t_ctrl;

endpackage

// ===== rtl/memory_test_sequencer.sv =====
// memory_test_sequencer: top level of the memory self-test engine
// depends on mts_pkg and mts_step
//
//  channel  direction  handshake             payload
//  in       input      i_in_valid/o_in_ready  i_start_req, i_read_data
//  out      output     o_out_valid/i_out_ready o_mem_write, o_mem_read, o_mem_address,
//                                              o_mem_write_data, o_test_status, o_fail_value
//  cfg      input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle; each item's result is registered and shown in the cycle after accept
// the result register frees up in the cycle it is taken, so in and out move together
// a stalled output holds the input off only while the result register is full
// config writes are always taken; synchronous reset clears status to idle and
// loads register defaults

module memory_test_sequencer import mts_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_start_req,
    input  logic [DATA_WIDTH-1:0] i_read_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_mem_write,
    output logic                  o_mem_read,
    output logic [ADDR_BITS-1:0]  o_mem_address,
    output logic [DATA_WIDTH-1:0] o_mem_write_data,
    output logic [1:0]            o_test_status,
    output logic [FAIL_W-1:0]     o_fail_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [1:0]            r_test_select;
    logic [15:0]           r_base;
    logic [OFF_W-1:0]      r_word_count;
    t_ctrl                 r_ctrl;
    t_ctrl                 n_ctrl;
    logic [DATA_WIDTH-1:0] r_pattern;
    logic [DATA_WIDTH-1:0] n_pattern;
    logic [DATA_WIDTH-1:0] r_expected;
    logic [DATA_WIDTH-1:0] n_expected;
    logic                  r_out_valid;
    logic                  r_mem_write;
    logic                  n_mem_write;
    logic                  r_mem_read;
    logic                  n_mem_read;
    logic [ADDR_BITS-1:0]  r_mem_address;
    logic [ADDR_BITS-1:0]  n_mem_address;
    logic [DATA_WIDTH-1:0] r_mem_write_data;
    logic [DATA_WIDTH-1:0] n_mem_write_data;
    logic [1:0]            r_status;
    logic [FAIL_W-1:0]     r_fail;
    logic                  in_fire;
    logic                  cfg_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    mts_step #(
        .DATA_WIDTH(DATA_WIDTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .i_ctrl             (r_ctrl),
        .i_pattern          (r_pattern),
        .i_expected         (r_expected),
        .i_start_req        (i_start_req),
        .i_read_data        (i_read_data),
        .i_test_select      (r_test_select),
        .i_base_word_address(r_base),
        .i_word_count       (r_word_count),
        .o_ctrl             (n_ctrl),
        .o_pattern          (n_pattern),
        .o_expected         (n_expected),
        .o_mem_write        (n_mem_write),
        .o_mem_read         (n_mem_read),
        .o_mem_address      (n_mem_address),
        .o_mem_write_data   (n_mem_write_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_select <= TS_DATA_BUS;
            r_base        <= '0;
            r_word_count  <= WORD_COUNT_RST;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_TEST_SELECT: r_test_select <= i_cfg_data[1:0];
                REG_BASE_ADDR:   r_base        <= i_cfg_data[15:0];
                REG_WORD_COUNT:  r_word_count  <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_pattern  <= '0;
            r_expected <= '0;
        end else if (in_fire) begin
            r_ctrl     <= n_ctrl;
            r_pattern  <= n_pattern;
            r_expected <= n_expected;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mem_write      <= n_mem_write;
            r_mem_read       <= n_mem_read;
            r_mem_address    <= n_mem_address;
            r_mem_write_data <= n_mem_write_data;
            r_status         <= n_ctrl.status;
            r_fail           <= n_ctrl.fail;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mem_write      = r_mem_write;
    assign o_mem_read       = r_mem_read;
    assign o_mem_address    = r_mem_address;
    assign o_mem_write_data = r_mem_write_data;
    assign o_test_status    = r_status;
    assign o_fail_value     = r_fail;

endmodule

// ===== rtl/mts_step.sv =====
// mts_step: next-state and access logic for one tick of the test sequencer
// depends on mts_pkg

module mts_step import mts_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_BITS  = 16
) (
    input  t_ctrl                  i_ctrl,
    input  logic [DATA_WIDTH-1:0]  i_pattern,
    input  logic [DATA_WIDTH-1:0]  i_expected,
    input  logic                   i_start_req,
    input  logic [DATA_WIDTH-1:0]  i_read_data,
    input  logic [1:0]             i_test_select,
    input  logic [15:0]            i_base_word_address,
    input  logic [OFF_W-1:0]       i_word_count,
    output t_ctrl                  o_ctrl,
    output logic [DATA_WIDTH-1:0]  o_pattern,
    output logic [DATA_WIDTH-1:0]  o_expected,
    output logic                   o_mem_write,
    output logic                   o_mem_read,
    output logic [ADDR_BITS-1:0]   o_mem_address,
    output logic [DATA_WIDTH-1:0]  o_mem_write_data
);

    localparam int REP = DATA_WIDTH / 2 + 1;
    localparam logic [2*REP-1:0] PAT_WIDE  = {REP{2'b10}};
    localparam logic [2*REP-1:0] ANTI_WIDE = {REP{2'b01}};
    localparam logic [DATA_WIDTH-1:0] PAT  = PAT_WIDE[DATA_WIDTH-1:0];
    localparam logic [DATA_WIDTH-1:0] ANTI = ANTI_WIDE[DATA_WIDTH-1:0];

    logic [3:0]            ph;
    logic [OFF_W-1:0]      scan;
    logic [OFF_W-1:0]      probe;
    logic                  pend;
    logic [1:0]            st;
    logic [FAIL_W-1:0]     fail;
    logic [DATA_WIDTH-1:0] pat;
    logic [DATA_WIDTH-1:0] expv;
    logic                  checked;
    logic                  done;
    logic                  acc_w;
    logic                  acc_r;
    logic [OFF_W-1:0]      acc_off;
    logic [DATA_WIDTH-1:0] acc_data;
    logic [OFF_W-1:0]      m;
    logic [17:0]           addr_sum;
    logic [31:0]           addr_wide;

    assign m = i_word_count - OFF_W'(1);

    always_comb begin
        ph       = i_ctrl.phase;
        scan     = i_ctrl.scan;
        probe    = i_ctrl.probe;
        pend     = i_ctrl.pending;
        st       = i_ctrl.status;
        fail     = i_ctrl.fail;
        pat      = i_pattern;
        expv     = i_expected;
        checked  = 1'b0;
        done     = 1'b0;
        acc_w    = 1'b0;
        acc_r    = 1'b0;
        acc_off  = '0;
        acc_data = '0;

        if (st != ST_RUN) begin
            if (i_start_req && i_test_select != TS_NONE) begin
                st    = ST_RUN;
                fail  = '0;
                pend  = 1'b0;
                probe = '0;
                case (i_test_select)
                    TS_DATA_BUS: begin
                        ph = PH_DB_WR; pat = DATA_WIDTH'(1); scan = '0;
                    end
                    TS_ADDR_BUS: begin
                        ph = PH_AB_FILL; pat = '0; scan = OFF_W'(1);
                    end
                    default: begin
                        ph = PH_DV_FILL; pat = DATA_WIDTH'(1); scan = '0;
                    end
                endcase
            end
        end else if (pend) begin
            pend    = 1'b0;
            checked = 1'b1;
            if (i_read_data != expv) begin
                case (ph)
                    PH_DB_WR:  fail = FAIL_W'(pat);
                    PH_AB_LOR: fail = FAIL_W'(probe);
                    default:   fail = FAIL_W'(scan);
                endcase
                st = ST_FAIL;
                ph = PH_IDLE;
            end
        end

        // phases are visited in code order; fall-through only moves forward
        if (!done && ph == PH_DB_WR) begin
            done = 1'b1;
            if (checked) pat = pat << 1;
            if (checked && pat == '0) begin
                st = ST_PASS; fail = '0; ph = PH_IDLE;
            end else begin
                acc_w = 1'b1; acc_off = '0; acc_data = pat; ph = PH_DB_RD;
            end
        end
        if (!done && ph == PH_DB_RD) begin
            done = 1'b1;
            acc_r = 1'b1; acc_off = '0; expv = pat; pend = 1'b1; ph = PH_DB_WR;
        end
        if (!done && ph == PH_AB_FILL) begin
            done = 1'b1;
            if ((scan & m) == '0) begin
                ph = PH_AB_HIB; done = 1'b0; checked = 1'b0;
            end else begin
                acc_w = 1'b1; acc_off = scan; acc_data = PAT; scan = scan << 1;
            end
        end
        if (!done && ph == PH_AB_HIB) begin
            done = 1'b1;
            acc_w = 1'b1; acc_off = '0; acc_data = ANTI;
            scan = OFF_W'(1); ph = PH_AB_HIR;
        end
        if (!done && ph == PH_AB_HIR) begin
            done = 1'b1;
            if (checked) scan = scan << 1;
            if ((scan & m) == '0) begin
                ph = PH_AB_HIE; done = 1'b0; checked = 1'b0;
            end else begin
                acc_r = 1'b1; acc_off = scan; expv = PAT; pend = 1'b1;
            end
        end
        if (!done && ph == PH_AB_HIE) begin
            done = 1'b1;
            acc_w = 1'b1; acc_off = '0; acc_data = PAT;
            probe = OFF_W'(1); ph = PH_AB_LOP;
        end
        if (!done && ph == PH_AB_LOP) begin
            done = 1'b1;
            if ((probe & m) == '0) begin
                st = ST_PASS; fail = '0; ph = PH_IDLE; pend = 1'b0;
            end else begin
                acc_w = 1'b1; acc_off = probe; acc_data = ANTI; ph = PH_AB_LO0;
            end
        end
        if (!done && ph == PH_AB_LO0) begin
            done = 1'b1;
            acc_r = 1'b1; acc_off = '0; expv = PAT; pend = 1'b1;
            scan = OFF_W'(1); ph = PH_AB_LOR;
        end
        if (!done && ph == PH_AB_LOR) begin
            done = 1'b1;
            if (scan == probe) scan = scan << 1;
            if ((scan & m) == '0) begin
                ph = PH_AB_LOE; done = 1'b0; checked = 1'b0;
            end else begin
                acc_r = 1'b1; acc_off = scan; expv = PAT; pend = 1'b1;
                scan = scan << 1;
            end
        end
        if (!done && ph == PH_AB_LOE) begin
            done = 1'b1;
            acc_w = 1'b1; acc_off = probe; acc_data = PAT;
            probe = probe << 1; ph = PH_AB_LOP;
        end
        if (!done && ph == PH_DV_FILL) begin
            done = 1'b1;
            if (scan >= i_word_count) begin
                scan = '0; pat = DATA_WIDTH'(1); ph = PH_DV_C1R;
                done = 1'b0; checked = 1'b0;
            end else begin
                acc_w = 1'b1; acc_off = scan; acc_data = pat;
                scan = scan + OFF_W'(1); pat = pat + DATA_WIDTH'(1);
            end
        end
        if (!done && ph == PH_DV_C1R) begin
            done = 1'b1;
            if (scan >= i_word_count) begin
                scan = '0; pat = DATA_WIDTH'(1); ph = PH_DV_C2R;
                done = 1'b0; checked = 1'b0;
            end else begin
                acc_r = 1'b1; acc_off = scan; expv = pat; pend = 1'b1;
                ph = PH_DV_C1W;
            end
        end
        if (!done && ph == PH_DV_C1W) begin
            done = 1'b1;
            acc_w = 1'b1; acc_off = scan; acc_data = ~pat;
            scan = scan + OFF_W'(1); pat = pat + DATA_WIDTH'(1); ph = PH_DV_C1R;
        end
        if (!done && ph == PH_DV_C2R) begin
            if (checked) begin
                scan = scan + OFF_W'(1); pat = pat + DATA_WIDTH'(1);
            end
            if (scan >= i_word_count) begin
                st = ST_PASS; fail = '0; ph = PH_IDLE; pend = 1'b0;
            end else begin
                acc_r = 1'b1; acc_off = scan; expv = ~pat; pend = 1'b1;
            end
        end
    end

    assign addr_sum  = {2'b00, i_base_word_address} + {1'b0, acc_off};
    assign addr_wide = 32'(addr_sum);

    assign o_ctrl.phase   = ph;
    assign o_ctrl.scan    = scan;
    assign o_ctrl.probe   = probe;
    assign o_ctrl.pending = pend;
    assign o_ctrl.status  = st;
    assign o_ctrl.fail    = fail;
    assign o_pattern      = pat;
    assign o_expected     = expv;
    assign o_mem_write    = acc_w;
    assign o_mem_read     = acc_r;
    assign o_mem_address  = (acc_w || acc_r) ? addr_wide[ADDR_BITS-1:0] : '0;
    assign o_mem_write_data = acc_data;

endmodule

// ===== rtl/mts_checker.sv =====
// mts_checker: port-level assertions for memory_test_sequencer, with its bind
// depends on mts_pkg

module mts_checker import mts_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_BITS  = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_mem_write,
    input logic                  o_mem_read,
    input logic [ADDR_BITS-1:0]  o_mem_address,
    input logic [DATA_WIDTH-1:0] o_mem_write_data,
    input logic [1:0]            o_test_status,
    input logic [FAIL_W-1:0]     o_fail_value
);

    // one access per tick at most
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_mem_write && o_mem_read))
        else $error("write and read issued together");

    a_quiet_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_mem_write && !o_mem_read |->
            o_mem_address == '0 && o_mem_write_data == '0)
        else $error("bus not quiet without access");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_test_status != ST_FAIL |-> o_fail_value == '0)
        else $error("fail value set without failure");

    a_no_access_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_test_status == ST_PASS || o_test_status == ST_FAIL) |->
            !o_mem_write && !o_mem_read)
        else $error("access issued outside a running test");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_mem_address) && $stable(o_test_status))
        else $error("stalled item changed");

endmodule

bind memory_test_sequencer mts_checker #(
    .DATA_WIDTH(DATA_WIDTH),
    .ADDR_BITS (ADDR_BITS)
) u_mts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_mem_write     (o_mem_write),
    .o_mem_read      (o_mem_read),
    .o_mem_address   (o_mem_address),
    .o_mem_write_data(o_mem_write_data),
    .o_test_status   (o_test_status),
    .o_fail_value    (o_fail_value)
);

// ===== bench/tb_memory_test_sequencer.sv =====
// tb_memory_test_sequencer: self-checking bench for the memory self-test sequencer
// drives start and read data from a behavioral memory and checks every access and status
// depends on mts_pkg and memory_test_sequencer

module tb_memory_test_sequencer import mts_pkg::*;;

    localparam int ITEM_TARGET    = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] PAT_AA = 32'hAAAAAAAA;
    localparam logic [31:0] PAT_55 = 32'h55555555;

    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [15:0] addr;
        logic [31:0] wdata;
        logic [1:0]  status;
        logic [31:0] fail;
        logic [63:0] stamp;
    } t_mem_access;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        start_req;
    logic [31:0] read_data;
    logic        out_valid;
    logic        out_ready;
    logic        mem_write;
    logic        mem_read;
    logic [15:0] mem_address;
    logic [31:0] mem_write_data;
    logic [1:0]  test_status;
    logic [31:0] fail_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    // predicted sequencer state and registers
    logic [3:0]  seq_phase;
    logic [16:0] seq_scan;
    logic [16:0] seq_probe;
    logic [31:0] seq_pattern;
    logic [31:0] seq_expected;
    logic        seq_pending;
    logic [1:0]  seq_status;
    logic [31:0] seq_fail;
    logic [1:0]  seq_sel;
    logic [15:0] seq_base;
    logic [16:0] seq_wcount;
    t_mem_access cur_access;

    t_mem_access expected_accesses[$];
    logic [31:0] mem_image [0:65535];
    logic        read_outstanding = 1'b0;
    logic [15:0] read_addr = '0;
    int          fault_countdown = -1;
    int          hold_request = 0;
    bit          no_idle = 1'b0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          launches[0:2];
    int          passes = 0;
    int          fails = 0;
    int          quiet_cycles = 0;

    memory_test_sequencer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_start_req     (start_req),
        .i_read_data     (read_data),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_mem_write     (mem_write),
        .o_mem_read      (mem_read),
        .o_mem_address   (mem_address),
        .o_mem_write_data(mem_write_data),
        .o_test_status   (test_status),
        .o_fail_value    (fail_value),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99, 0);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic void reset_predictor();
        seq_sel      = TS_DATA_BUS;
        seq_base     = '0;
        seq_wcount   = WORD_COUNT_RST;
        seq_phase    = PH_IDLE;
        seq_scan     = '0;
        seq_probe    = '0;
        seq_pattern  = '0;
        seq_expected = '0;
        seq_pending  = 1'b0;
        seq_status   = ST_IDLE;
        seq_fail     = '0;
    endfunction

    function automatic void issue_write(logic [16:0] off, logic [31:0] data);
        cur_access.wr    = 1'b1;
        cur_access.addr  = seq_base + off[15:0];
        cur_access.wdata = data;
    endfunction

    function automatic void issue_read(logic [16:0] off, logic [31:0] want);
        cur_access.rd = 1'b1;
        cur_access.addr = seq_base + off[15:0];
        seq_expected = want;
        seq_pending = 1'b1;
    endfunction

    function automatic void finish_test(logic [1:0] st, logic [31:0] val);
        seq_status  = st;
        seq_fail    = val;
        seq_phase   = PH_IDLE;
        seq_pending = 1'b0;
        if (st == ST_PASS) passes++;
        else fails++;
    endfunction

    function automatic t_mem_access step_sequencer(logic start, logic [31:0] rdata);
        logic [16:0] m;
        logic [31:0] fv;
        bit          checked;
        bit          again;
        cur_access = '0;
        m = seq_wcount - 17'd1;
        checked = 1'b0;
        if (seq_status != ST_RUN) begin
            if (start && seq_sel != TS_NONE) begin
                launches[seq_sel]++;
                seq_status  = ST_RUN;
                seq_fail    = '0;
                seq_pending = 1'b0;
                seq_probe   = '0;
                case (seq_sel)
                    TS_DATA_BUS: begin
                        seq_phase = PH_DB_WR; seq_pattern = 32'd1; seq_scan = 17'd0;
                    end
                    TS_ADDR_BUS: begin
                        seq_phase = PH_AB_FILL; seq_pattern = 32'd0; seq_scan = 17'd1;
                    end
                    default: begin
                        seq_phase = PH_DV_FILL; seq_pattern = 32'd1; seq_scan = 17'd0;
                    end
                endcase
            end
        end else if (seq_pending) begin
            seq_pending = 1'b0;
            checked = 1'b1;
            if (rdata != seq_expected) begin
                case (seq_phase)
                    PH_DB_WR:  fv = seq_pattern;
                    PH_AB_LOR: fv = {15'd0, seq_probe};
                    default:   fv = {15'd0, seq_scan};
                endcase
                finish_test(ST_FAIL, fv);
            end
        end

        do begin
            again = 1'b0;
            case (seq_phase)
                PH_DB_WR: begin
                    if (checked) seq_pattern = seq_pattern << 1;
                    if (checked && seq_pattern == 32'd0) begin
                        finish_test(ST_PASS, 32'd0);
                    end else begin
                        issue_write(17'd0, seq_pattern);
                        seq_phase = PH_DB_RD;
                    end
                end
                PH_DB_RD: begin
                    issue_read(17'd0, seq_pattern);
                    seq_phase = PH_DB_WR;
                end
                PH_AB_FILL: begin
                    if ((seq_scan & m) == 17'd0) begin
                        seq_phase = PH_AB_HIB;
                        again = 1'b1;
                    end else begin
                        issue_write(seq_scan, PAT_AA);
                        seq_scan = seq_scan << 1;
                    end
                end
                PH_AB_HIB: begin
                    issue_write(17'd0, PAT_55);
                    seq_scan = 17'd1;
                    seq_phase = PH_AB_HIR;
                end
                PH_AB_HIR: begin
                    if (checked) seq_scan = seq_scan << 1;
                    if ((seq_scan & m) == 17'd0) begin
                        seq_phase = PH_AB_HIE;
                        again = 1'b1;
                    end else begin
                        issue_read(seq_scan, PAT_AA);
                    end
                end
                PH_AB_HIE: begin
                    issue_write(17'd0, PAT_AA);
                    seq_probe = 17'd1;
                    seq_phase = PH_AB_LOP;
                end
                PH_AB_LOP: begin
                    if ((seq_probe & m) == 17'd0) begin
                        finish_test(ST_PASS, 32'd0);
                    end else begin
                        issue_write(seq_probe, PAT_55);
                        seq_phase = PH_AB_LO0;
                    end
                end
                PH_AB_LO0: begin
                    issue_read(17'd0, PAT_AA);
                    seq_scan = 17'd1;
                    seq_phase = PH_AB_LOR;
                end
                PH_AB_LOR: begin
                    if (seq_scan == seq_probe) seq_scan = seq_scan << 1;
                    if ((seq_scan & m) == 17'd0) begin
                        seq_phase = PH_AB_LOE;
                        again = 1'b1;
                    end else begin
                        issue_read(seq_scan, PAT_AA);
                        seq_scan = seq_scan << 1;
                    end
                end
                PH_AB_LOE: begin
                    issue_write(seq_probe, PAT_AA);
                    seq_probe = seq_probe << 1;
                    seq_phase = PH_AB_LOP;
                end
                PH_DV_FILL: begin
                    if (seq_scan >= seq_wcount) begin
                        seq_scan = 17'd0;
                        seq_pattern = 32'd1;
                        seq_phase = PH_DV_C1R;
                        again = 1'b1;
                    end else begin
                        issue_write(seq_scan, seq_pattern);
                        seq_scan = seq_scan + 17'd1;
                        seq_pattern = seq_pattern + 32'd1;
                    end
                end
                PH_DV_C1R: begin
                    if (seq_scan >= seq_wcount) begin
                        seq_scan = 17'd0;
                        seq_pattern = 32'd1;
                        seq_phase = PH_DV_C2R;
                        again = 1'b1;
                    end else begin
                        issue_read(seq_scan, seq_pattern);
                        seq_phase = PH_DV_C1W;
                    end
                end
                PH_DV_C1W: begin
                    issue_write(seq_scan, ~seq_pattern);
                    seq_scan = seq_scan + 17'd1;
                    seq_pattern = seq_pattern + 32'd1;
                    seq_phase = PH_DV_C1R;
                end
                PH_DV_C2R: begin
                    if (checked) begin
                        seq_scan = seq_scan + 17'd1;
                        seq_pattern = seq_pattern + 32'd1;
                    end
                    if (seq_scan >= seq_wcount) finish_test(ST_PASS, 32'd0);
                    else issue_read(seq_scan, ~seq_pattern);
                end
                default: begin
                end
            endcase
            checked = 1'b0;
        end while (again);

        cur_access.status = seq_status;
        cur_access.fail   = seq_fail;
        return cur_access;
    endfunction

    task automatic send_item(logic start, logic [31:0] rdata);
        int          gap;
        t_mem_access res;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        start_req = start;
        read_data = rdata;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        res = step_sequencer(start, rdata);
        res.stamp = $time;
        expected_accesses.push_back(res);
        items_sent++;
        if (res.wr) mem_image[res.addr] = res.wdata;
        read_outstanding = res.rd;
        read_addr = res.addr;
    endtask

    // a pending read gets the memory image word, maybe one bit flipped; else random
    task automatic apply_tick(logic start);
        logic [31:0] rdata;
        if (read_outstanding) begin
            rdata = mem_image[read_addr];
            if (fault_countdown == 0) rdata = rdata ^ (32'd1 << $urandom_range(31, 0));
            fault_countdown--;
        end else begin
            rdata = $urandom;
        end
        send_item(start, rdata);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_accesses.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [16:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_TEST_SELECT: seq_sel = value[1:0];
            REG_BASE_ADDR:   seq_base = value[15:0];
            REG_WORD_COUNT:  seq_wcount = value;
            default: begin
            end
        endcase
    endtask

    task automatic configure(logic [1:0] sel, logic [15:0] base, logic [16:0] wc);
        wait_drained();
        write_register(REG_TEST_SELECT, {15'd0, sel});
        write_register(REG_BASE_ADDR, {1'b0, base});
        write_register(REG_WORD_COUNT, wc);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_memory_test(logic [1:0] sel, logic [15:0] base, logic [16:0] wc,
                                   int fault_at);
        configure(sel, base, wc);
        fault_countdown = fault_at;
        apply_tick(1'b1);
        // stray starts while running must be ignored
        while (seq_status == ST_RUN) apply_tick($urandom_range(19, 0) == 0);
        apply_tick(1'b0);
    endtask

    task automatic test_directed_corners();
        send_item(1'b0, 32'h00000000);
        send_item(1'b0, 32'hFFFFFFFF);
        send_item(1'b0, $urandom);
        run_memory_test(TS_DATA_BUS, 16'hFFFF, WORD_COUNT_RST, 0);
        run_memory_test(TS_NONE, 16'hFFFF, 17'd0, -1);
        run_memory_test(TS_DEVICE, 16'h0000, 17'd0, -1);
        run_memory_test(TS_ADDR_BUS, 16'h8000, 17'd1, -1);
        run_memory_test(TS_DEVICE, 16'hFFFF, 17'd1, 1);
        run_memory_test(TS_ADDR_BUS, 16'hFFFE, 17'd2, 0);
    endtask

    task automatic test_midrun_reconfigure();
        logic [15:0] base;
        base = 16'($urandom);
        configure(TS_DEVICE, base, 17'd12);
        fault_countdown = -1;
        apply_tick(1'b1);
        repeat (20) apply_tick(1'b0);
        // shrink the word count while the device test is in its check pass
        configure(TS_DATA_BUS, base, 17'd5);
        while (seq_status == ST_RUN) apply_tick(1'b0);
        apply_tick(1'b0);
    endtask

    task automatic test_output_backpressure();
        configure(TS_DATA_BUS, 16'h1234, WORD_COUNT_RST);
        fault_countdown = -1;
        no_idle = 1'b1;
        hold_request = 200;
        apply_tick(1'b1);
        while (seq_status == ST_RUN) apply_tick(1'b0);
        apply_tick(1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_runs();
        int          r;
        logic [1:0]  sel;
        logic [15:0] base;
        logic [16:0] wc;
        int          fault_at;
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(99, 0);
            if (r < 25) sel = TS_DATA_BUS;
            else if (r < 50) sel = TS_ADDR_BUS;
            else if (r < 95) sel = TS_DEVICE;
            else sel = TS_NONE;

            r = $urandom_range(9, 0);
            if (r == 0) base = 16'h0000;
            else if (r == 1) base = 16'hFFFF;
            else base = 16'($urandom);

            r = $urandom_range(99, 0);
            if (sel == TS_ADDR_BUS) begin
                if (r < 50) wc = 17'($urandom_range(64, 1));
                else if (r < 70) wc = 17'd1 << $urandom_range(16, 0);
                else if (r < 85) wc = 17'($urandom_range(17'h1FFFF, 0));
                else if (r < 93) wc = 17'd0;
                else wc = WORD_COUNT_RST;
            end else if (sel == TS_DEVICE) begin
                if (r < 80) wc = 17'($urandom_range(16, 1));
                else if (r < 90) wc = 17'd0;
                else wc = 17'($urandom_range(120, 17));
            end else begin
                wc = 17'($urandom_range(17'h1FFFF, 0));
            end

            fault_at = ($urandom_range(99, 0) < 35) ? $urandom_range(30, 0) : -1;
            no_idle = ($urandom_range(4, 0) == 0);
            run_memory_test(sel, base, wc, fault_at);
        end
        no_idle = 1'b0;
    endtask

    initial begin : drive_out_ready
        int stall;
        stall = 0;
        out_ready = 1'b1;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                out_ready = 1'b0;
                hold_request--;
            end else if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else begin
                out_ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want === got) return;
        mismatches++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
    endfunction

    always @(posedge clk) begin : check_results
        t_mem_access want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_accesses.size() == 0 || expected_accesses[0].stamp == $time) begin
                mismatches++;
                $display("%0t: unexpected item, expected none actual addr %h status %0d",
                         $time, mem_address, test_status);
            end else begin
                want = expected_accesses.pop_front();
                compare_field("mem_write", 32'(want.wr), 32'(mem_write));
                compare_field("mem_read", 32'(want.rd), 32'(mem_read));
                compare_field("mem_address", 32'(want.addr), 32'(mem_address));
                compare_field("mem_write_data", want.wdata, mem_write_data);
                compare_field("test_status", 32'(want.status), 32'(test_status));
                compare_field("fail_value", want.fail, fail_value);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d items still awaited", $time,
                         expected_accesses.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : main_sequence
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        start_req = 1'b0;
        read_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TEST_SELECT;
        cfg_data  = '0;
        for (int i = 0; i < 3; i++) launches[i] = 0;
        for (int i = 0; i < 65536; i++) mem_image[i] = $urandom;
        reset_predictor();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_midrun_reconfigure();
        test_output_backpressure();
        test_random_runs();

        wait_drained();
        repeat (5) @(posedge clk);
        $display("ran %0d items: %0d data bus, %0d address bus, %0d device tests launched",
                 items_sent, launches[0], launches[1], launches[2]);
        $display("tests ended with %0d passes and %0d failures, %0d mismatches",
                 passes, fails, mismatches);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
